### design/stc_pkg.sv
// Shared types and constants for the scrolling text console.
package stc_pkg;

   // Opcodes of an incoming request.
   typedef enum logic [1:0] {
      OP_PUT  = 2'd0,
      OP_LOAD = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   // Command kinds after classification in the front end.
   typedef enum logic [1:0] {
      CMD_CHAR    = 2'd0,
      CMD_NEWLINE = 2'd1,
      CMD_LOAD    = 2'd2,
      CMD_READ    = 2'd3
   } cmd_kind_type;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] PIXEL_ON     = 8'hff;
   localparam logic [7:0] PIXEL_OFF    = 8'h00;

   // Command queue between front and back.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Result queue.
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
      logic [8:0]   glyph_word_index;
      logic [31:0]  glyph_word;
      logic [9:0]   pixel_x;
      logic [8:0]   pixel_y;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } rsp_wr_type;

endpackage

### design/stc_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module stc_front #(
   parameter int GLYPH_COUNT = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            opcode,
   input  logic [7:0]            char_code,
   input  logic [8:0]            glyph_word_index,
   input  logic [31:0]           glyph_word,
   input  logic [9:0]            pixel_x,
   input  logic [8:0]            pixel_y,
   output stc_pkg::cmd_slot_type head,
   input  logic                  take
);

   localparam int STORE_DEPTH = GLYPH_COUNT * 4;

   stc_pkg::cmd_type                 cmd_q_ff [stc_pkg::CMD_DEPTH];
   logic [stc_pkg::CMD_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [stc_pkg::CMD_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [stc_pkg::CMD_CNT_W-1:0]    count_ff, count_in;
   logic                             keep;
   logic                             wr;
   stc_pkg::cmd_type                 cmd_new;

   always_comb begin
      cmd_new.char_code        = char_code;
      cmd_new.glyph_word_index = glyph_word_index;
      cmd_new.glyph_word       = glyph_word;
      cmd_new.pixel_x          = pixel_x;
      cmd_new.pixel_y          = pixel_y;
      keep                     = 1'b0;
      cmd_new.kind             = stc_pkg::CMD_READ;
      case (opcode)
         stc_pkg::OP_PUT: begin
            keep = 1'b1;
            if (char_code == stc_pkg::NEWLINE_CODE) begin
               cmd_new.kind = stc_pkg::CMD_NEWLINE;
            end else begin
               cmd_new.kind = stc_pkg::CMD_CHAR;
            end
         end
         stc_pkg::OP_LOAD: begin
            // Loads past the end of the font store are dropped here.
            keep         = ({2'b0, glyph_word_index} < 11'(STORE_DEPTH));
            cmd_new.kind = stc_pkg::CMD_LOAD;
         end
         stc_pkg::OP_READ: begin
            keep         = 1'b1;
            cmd_new.kind = stc_pkg::CMD_READ;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign full = (count_ff == stc_pkg::CMD_CNT_W'(stc_pkg::CMD_DEPTH));
   assign wr   = push && !full && keep;

   always_comb begin
      wr_ptr_in = wr   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + stc_pkg::CMD_CNT_W'(wr) - stc_pkg::CMD_CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = cmd_q_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= stc_pkg::CMD_CNT_W'(stc_pkg::CMD_DEPTH))
      else $error("command queue count exceeds its depth");

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      take |-> head.valid)
      else $error("back end took a command from an empty queue");

   a_drop_load: assert property (@(posedge clock) disable iff (reset)
      (push && !full && opcode == stc_pkg::OP_LOAD
       && {2'b0, glyph_word_index} >= 11'(STORE_DEPTH)) |=> $stable(count_ff) || $past(take))
      else $error("out-of-range glyph load was queued");

endmodule

### design/stc_rsp_queue.sv
// Result queue that holds pixel values until the consumer pops them.
module stc_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  stc_pkg::rsp_wr_type    wr,
   output logic                   room_full,
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             value
);

   logic [7:0]                     data_ff [stc_pkg::RSP_DEPTH];
   logic [stc_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [stc_pkg::RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [stc_pkg::RSP_CNT_W-1:0]  count_ff, count_in;
   logic                           rd;

   assign empty     = (count_ff == '0);
   assign room_full = (count_ff == stc_pkg::RSP_CNT_W'(stc_pkg::RSP_DEPTH));
   assign rd        = pop && !empty;
   assign value     = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + stc_pkg::RSP_CNT_W'(wr.valid) - stc_pkg::RSP_CNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         data_ff[wr_ptr_ff] <= wr.value;
      end
   end

endmodule

### design/stc_back.sv
// Back end: text ring, font store and the pixel read sequencer.
module stc_back #(
   parameter int TEXT_ROWS    = 24,
   parameter int TEXT_COLS    = 64,
   parameter int GLYPH_HEIGHT = 16,
   parameter int GLYPH_COUNT  = 128,
   parameter int SCREEN_WIDTH = 640
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stc_pkg::cmd_slot_type head,
   output logic                  take,
   input  logic                  rsp_full,
   output stc_pkg::rsp_wr_type   rsp_wr
);

   localparam int RW          = $clog2(TEXT_ROWS);
   localparam int CW          = $clog2(TEXT_COLS + 1);
   localparam int CELL_DEPTH  = TEXT_ROWS * TEXT_COLS;
   localparam int CAW         = $clog2(CELL_DEPTH);
   localparam int STORE_DEPTH = GLYPH_COUNT * 4;
   localparam int GAW         = $clog2(STORE_DEPTH);
   // Text row = pixel row / glyph height, done as a multiply by a rounded-up reciprocal.
   localparam int DIV_SH      = 20;
   localparam int DIV_RECIP   = (2 ** DIV_SH + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOCATE = 4'b0010,
      ST_CHAR   = 4'b0100,
      ST_GLYPH  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [RW-1:0]     first_ff, first_in;
   logic [RW-1:0]     last_ff, last_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     row_len_ff [TEXT_ROWS];

   logic [7:0]        cell_mem [CELL_DEPTH];
   logic [31:0]       glyph_mem [STORE_DEPTH];
   logic [7:0]        cell_rd_ff;
   logic [31:0]       glyph_rd_ff;

   logic [9:0]        x_ff;
   logic [8:0]        y_ff;
   logic [8:0]        trow_ff;
   logic [3:0]        gr_ff;
   logic              hit_ff;

   logic [RW-1:0]     next_last;
   logic [RW-1:0]     next_first;
   logic [RW-1:0]     tgt_row;
   logic [CW-1:0]     tgt_col;
   logic              len_we;
   logic [RW-1:0]     len_row;
   logic [CW-1:0]     len_val;
   logic              cell_we;
   logic [CAW-1:0]    cell_waddr;
   logic              glyph_we;

   logic [28:0]       div_prod;
   logic [6:0]        col;
   logic [RW:0]       ring_sum;
   logic [RW-1:0]     ring;
   logic [CW-1:0]     ring_len;
   logic              in_area;
   logic              hit_locate;
   logic [8:0]        trow_mult;
   logic [8:0]        gr_diff;
   logic [CAW-1:0]    cell_raddr;
   logic [GAW-1:0]    glyph_raddr;
   logic              ch_ok;

   assign take = (state_ff == ST_IDLE) && head.valid
                 && (head.cmd.kind != stc_pkg::CMD_READ || !rsp_full);

   assign next_last  = (last_ff == RW'(TEXT_ROWS - 1))  ? '0 : last_ff + 1'b1;
   assign next_first = (first_ff == RW'(TEXT_ROWS - 1)) ? '0 : first_ff + 1'b1;

   // Put, newline and load all finish in the cycle they are taken.
   always_comb begin
      state_in  = state_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      cursor_in = cursor_ff;
      tgt_row   = last_ff;
      tgt_col   = cursor_ff;
      len_we    = 1'b0;
      len_row   = next_last;
      len_val   = '0;
      cell_we   = 1'b0;
      glyph_we  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (head.cmd.kind)
                  stc_pkg::CMD_NEWLINE: begin
                     last_in   = next_last;
                     cursor_in = '0;
                     if (next_last == first_ff) begin
                        first_in = next_first;
                     end
                     len_we  = 1'b1;
                     len_row = next_last;
                     len_val = '0;
                  end
                  stc_pkg::CMD_CHAR: begin
                     // A full row wraps to a fresh line before the write.
                     if (cursor_ff == CW'(TEXT_COLS)) begin
                        last_in = next_last;
                        tgt_row = next_last;
                        tgt_col = '0;
                        if (next_last == first_ff) begin
                           first_in = next_first;
                        end
                     end
                     cell_we   = 1'b1;
                     cursor_in = tgt_col + 1'b1;
                     len_we    = 1'b1;
                     len_row   = tgt_row;
                     len_val   = tgt_col + 1'b1;
                  end
                  stc_pkg::CMD_LOAD: begin
                     glyph_we = 1'b1;
                  end
                  stc_pkg::CMD_READ: begin
                     state_in = ST_LOCATE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOCATE: state_in = ST_CHAR;
         ST_CHAR:   state_in = ST_GLYPH;
         ST_GLYPH:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign cell_waddr = CAW'(tgt_row) * CAW'(TEXT_COLS) + CAW'(tgt_col);

   // Pixel read address logic: text row, ring row, cell address and area checks, glyph check and glyph address.
   always_comb begin
      div_prod   = 29'(head.cmd.pixel_y) * 29'(DIV_RECIP);
      col        = x_ff[9:3];
      ring_sum   = (RW + 1)'(first_ff) + (RW + 1)'(trow_ff);
      ring       = (ring_sum >= (RW + 1)'(TEXT_ROWS)) ?
                   RW'(ring_sum - (RW + 1)'(TEXT_ROWS)) : RW'(ring_sum);
      ring_len   = row_len_ff[ring];
      in_area    = ({1'b0, x_ff} < 11'(SCREEN_WIDTH))
                   && ({1'b0, col} < 8'(TEXT_COLS))
                   && (trow_ff < 9'(TEXT_ROWS));
      hit_locate = in_area && ({1'b0, col} < 8'(ring_len));
      trow_mult  = trow_ff * 9'(GLYPH_HEIGHT);
      gr_diff    = y_ff - trow_mult;
      cell_raddr = CAW'(ring) * CAW'(TEXT_COLS) + CAW'(col);
      ch_ok      = ({1'b0, cell_rd_ff} < 9'(GLYPH_COUNT));
      glyph_raddr = GAW'({cell_rd_ff, gr_ff[3:2]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         first_ff  <= '0;
         last_ff   <= '0;
         cursor_ff <= '0;
         for (int i = 0; i < TEXT_ROWS; i++) begin
            row_len_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         cursor_ff <= cursor_in;
         if (len_we) begin
            row_len_ff[len_row] <= len_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff    <= head.cmd.pixel_x;
            y_ff    <= head.cmd.pixel_y;
            trow_ff <= div_prod[DIV_SH+8:DIV_SH];
         end
         ST_LOCATE: begin
            hit_ff <= hit_locate;
            gr_ff  <= gr_diff[3:0];
         end
         ST_CHAR: begin
            hit_ff <= hit_ff && ch_ok;
         end
         default: begin
            hit_ff <= hit_ff;
         end
      endcase
   end

   // Cells beyond a row's length are never shown, so the cells need no clearing.
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= head.cmd.char_code;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[GAW'(head.cmd.glyph_word_index)] <= head.cmd.glyph_word;
      end
      glyph_rd_ff <= glyph_mem[glyph_raddr];
   end

   // Bit 31 is the leftmost pixel of the first glyph row in the word.
   assign rsp_wr.valid = (state_ff == ST_GLYPH);
   assign rsp_wr.value = (hit_ff && glyph_rd_ff[~{gr_ff[1:0], x_ff[2:0]}]) ?
                         stc_pkg::PIXEL_ON : stc_pkg::PIXEL_OFF;

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CW'(TEXT_COLS))
      else $error("cursor ran past the end of the row");

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      (first_ff < RW'(TEXT_ROWS)) && (last_ff < RW'(TEXT_ROWS)))
      else $error("ring pointer out of range");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (take && head.cmd.kind == stc_pkg::CMD_READ) |-> ##3 rsp_wr.valid)
      else $error("pixel read did not produce its result on time");

   a_read_room: assert property (@(posedge clock) disable iff (reset)
      rsp_wr.valid |-> !rsp_full)
      else $error("result written into a full result queue");

endmodule

### design/scrolling_text_console.sv
// Scrolling text console: ring of text rows, glyph store and a per-pixel read port.
// An accepted request is registered in the command queue before it reaches the back end.
// Put, newline and glyph load requests are carried out one per cycle while the back end is idle.
// A pixel read steps the back end through its locate, char and glyph states (row lookup, cell memory
// read, glyph memory read) before its result is written into the result queue.
// Reset clears the ring pointers, cursor, row lengths and both queues; memories keep contents.
module scrolling_text_console #(
   parameter int TEXT_ROWS    = 24,
   parameter int TEXT_COLS    = 64,
   parameter int GLYPH_HEIGHT = 16,
   parameter int GLYPH_COUNT  = 128,
   parameter int SCREEN_WIDTH = 640
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [8:0]  req_glyph_word_index,
   input  logic [31:0] req_glyph_word,
   input  logic [9:0]  req_pixel_x,
   input  logic [8:0]  req_pixel_y,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_pixel_value
);

   stc_pkg::cmd_slot_type head;
   logic                  take;
   logic                  rsp_full;
   stc_pkg::rsp_wr_type   rsp_wr;

   stc_front #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .opcode           (req_opcode),
      .char_code        (req_char_code),
      .glyph_word_index (req_glyph_word_index),
      .glyph_word       (req_glyph_word),
      .pixel_x          (req_pixel_x),
      .pixel_y          (req_pixel_y),
      .head             (head),
      .take             (take)
   );

   stc_back #(
      .TEXT_ROWS    (TEXT_ROWS),
      .TEXT_COLS    (TEXT_COLS),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_COUNT  (GLYPH_COUNT),
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .take     (take),
      .rsp_full (rsp_full),
      .rsp_wr   (rsp_wr)
   );

   stc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (rsp_wr),
      .room_full (rsp_full),
      .empty     (empty),
      .pop       (pop),
      .value     (rsp_pixel_value)
   );

endmodule
